[rtl/core/ppw_pkg.sv]
// ----------------------------------------------------------------------------
// ppw_pkg
// Shared types and command codes for the point projection block.
// ----------------------------------------------------------------------------
package ppw_pkg;

	typedef enum logic [1:0] {
		CMD_LOAD_MODEL = 2'd0,
		CMD_LOAD_PROJ  = 2'd1,
		CMD_PROJECT    = 2'd2,
		CMD_NONE       = 2'd3
	} cmd_t;

	localparam logic [1:0] CFG_VP_X = 2'd0;
	localparam logic [1:0] CFG_VP_Y = 2'd1;
	localparam logic [1:0] CFG_VP_W = 2'd2;
	localparam logic [1:0] CFG_VP_H = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MODEL,
		ST_PROJ,
		ST_DIV_X,
		ST_DIV_Y,
		ST_DIV_Z,
		ST_MAP_X,
		ST_MAP_Y,
		ST_MAP_Z,
		ST_OUT
	} state_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if (v > 66'sd2147483647) return 32'sh7fffffff;
		if (v < -66'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

endpackage

[rtl/core/point_projection_to_window.sv]
// ----------------------------------------------------------------------------
// point_projection_to_window
// Fixed-point vertex projection: object point to window coordinates.
// ----------------------------------------------------------------------------
// Input channel s_axis: one beat carries a command. Load commands write one
// element of the model or projection matrix (both in one synchronous memory),
// return no beat and are accepted back to back, one per cycle while idle and
// no result waits. A project command returns one beat on m_axis with the
// valid flag and the window x, y, z coordinates after two passes of 16
// multiply-accumulate steps, one memory read each, then three signed
// divisions by clip w in a radix-2 divider of 2*FRAC_BITS+34 steps each,
// three viewport mapping steps and one output step. When clip w is zero the
// divisions and mapping are skipped; the beat then carries all zeros.
// One item is worked on at a time; s_axis_tready is low while a projection
// runs or while a result waits on m_axis, so the next beat is taken the cycle
// after the result beat. The output register holds the beat while
// m_axis_tready is low.
// Reset clears control state and sets the viewport to 0,0,640,480. The
// matrix memory starts as zero through per-entry valid bits.
// Config: cfg_we, cfg_index, cfg_wdata; write only while idle.
// ----------------------------------------------------------------------------
module point_projection_to_window
	import ppw_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [15:0]  cfg_wdata,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// command[1:0], element_index[5:2], element_value[37:6], object_x[69:38],
	// object_y[101:70], object_z[133:102], zero pad [135:134]
	input  logic [135:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// projection_valid[0], window_x[32:1], window_y[64:33], window_z[96:65],
	// zero pad [103:97]
	output logic [103:0] m_axis_tdata
);

	localparam int DW = 2 * FRAC_BITS + 34;
	localparam int DSTEPS = DW + 1;

	logic signed [15:0] vp_x_q, vp_y_q;
	logic [14:0]        vp_w_q, vp_h_q;

	logic signed [31:0] mem [32];
	logic [31:0]        vld_q;
	logic signed [31:0] rd_s1;
	logic               rd_ok_s1;

	state_t state_q, state_d;
	logic [4:0]  step_q;
	logic        rd_pend_q;
	logic signed [31:0] src_q [4];
	logic signed [31:0] dst_q [4];
	logic signed [65:0] acc_q;
	logic [6:0]  dcnt_q;
	logic [DW-1:0] rem_q, quo_q, den_q;
	logic        neg_q;
	logic signed [31:0] n_q [3];
	logic        ovalid_q;
	logic signed [31:0] ox_q, oy_q, oz_q;
	logic        ptrue_q;

	wire logic [1:0]  in_cmd = s_axis_tdata[1:0];
	wire logic [3:0]  in_idx = s_axis_tdata[5:2];
	wire logic signed [31:0] in_val = s_axis_tdata[37:6];
	wire logic        acc_in = s_axis_tvalid && s_axis_tready;

	assign s_axis_tready = (state_q == ST_IDLE) && !ovalid_q;
	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata = {7'd0, oz_q, oy_q, ox_q, ptrue_q};

	// memory read address: row r=step[3:2], col c=step[1:0], elem c*4+r
	logic [4:0] raddr;
	assign raddr = {state_q == ST_PROJ, step_q[1:0], step_q[3:2]};

	always_ff @(posedge clk) begin
		if (acc_in && (in_cmd == CMD_LOAD_MODEL || in_cmd == CMD_LOAD_PROJ))
			mem[{in_cmd[0], in_idx}] <= in_val;
		rd_s1 <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rd_ok_s1 <= 1'b0;
			vp_x_q <= '0;
			vp_y_q <= '0;
			vp_w_q <= 15'd640;
			vp_h_q <= 15'd480;
		end else begin
			if (acc_in && (in_cmd == CMD_LOAD_MODEL || in_cmd == CMD_LOAD_PROJ))
				vld_q[{in_cmd[0], in_idx}] <= 1'b1;
			rd_ok_s1 <= vld_q[raddr];
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_VP_X: vp_x_q <= cfg_wdata;
					CFG_VP_Y: vp_y_q <= cfg_wdata;
					CFG_VP_W: vp_w_q <= cfg_wdata[14:0];
					CFG_VP_H: vp_h_q <= cfg_wdata[14:0];
					default: ;
				endcase
			end
		end
	end

	logic signed [31:0] mval;
	logic signed [63:0] prod;
	logic signed [65:0] acc_nx;
	assign mval = rd_ok_s1 ? rd_s1 : 32'sd0;
	assign prod = mval * src_q[step_q[1:0] - 2'd1];
	assign acc_nx = acc_q + 66'(prod >>> FRAC_BITS);

	// divider
	logic [DW-1:0] rem_sh, rem_sub;
	logic          rem_ge;
	assign rem_sh = {rem_q[DW-2:0], quo_q[DW-1]};
	assign rem_ge = rem_sh >= den_q;
	assign rem_sub = rem_sh - den_q;

	logic signed [DW:0] qs;
	assign qs = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

	// map stage
	logic signed [33:0] onepn;
	logic signed [65:0] mapv;
	logic signed [65:0] mapq;
	always_comb begin
		onepn = 34'sd0;
		mapv = 66'sd0;
		unique case (state_q)
			ST_MAP_X: begin
				onepn = (34'sd1 <<< FRAC_BITS) + 34'(n_q[0]);
				mapv = (66'(vp_x_q) <<< (FRAC_BITS + 1))
					+ 66'(onepn * $signed({1'b0, vp_w_q}));
			end
			ST_MAP_Y: begin
				onepn = (34'sd1 <<< FRAC_BITS) + 34'(n_q[1]);
				mapv = (66'(vp_y_q) <<< (FRAC_BITS + 1))
					+ 66'(onepn * $signed({1'b0, vp_h_q}));
			end
			default: begin
				onepn = (34'sd1 <<< FRAC_BITS) + 34'(n_q[2]);
				mapv = 66'(onepn);
			end
		endcase
		mapq = mapv >>> (FRAC_BITS + 1);
		if (mapv < 0 && (mapv & ((66'sd1 <<< (FRAC_BITS + 1)) - 66'sd1)) != 0)
			mapq = mapq + 66'sd1;
	end

	logic signed [31:0] divsrc;
	always_comb begin
		unique case (state_d)
			ST_DIV_Y: divsrc = dst_q[1];
			ST_DIV_Z: divsrc = dst_q[2];
			default:  divsrc = dst_q[0];
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (acc_in && in_cmd == CMD_PROJECT) state_d = ST_MODEL;
			ST_MODEL: if (rd_pend_q && step_q == 5'd16) state_d = ST_PROJ;
			ST_PROJ: if (rd_pend_q && step_q == 5'd16)
				state_d = (sat32(acc_nx) == 32'sd0) ? ST_OUT : ST_DIV_X;
			ST_DIV_X: if (dcnt_q == 7'(DSTEPS)) state_d = ST_DIV_Y;
			ST_DIV_Y: if (dcnt_q == 7'(DSTEPS)) state_d = ST_DIV_Z;
			ST_DIV_Z: if (dcnt_q == 7'(DSTEPS)) state_d = ST_MAP_X;
			ST_MAP_X: state_d = ST_MAP_Y;
			ST_MAP_Y: state_d = ST_MAP_Z;
			ST_MAP_Z: state_d = ST_OUT;
			ST_OUT:   state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			rd_pend_q <= 1'b0;
			dcnt_q <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ovalid_q && m_axis_tready) ovalid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					rd_pend_q <= 1'b0;
				end
				ST_MODEL, ST_PROJ: begin
					rd_pend_q <= (step_q != 5'd16);
					step_q <= (step_q == 5'd16) ? 5'd0 : step_q + 5'd1;
				end
				ST_DIV_X, ST_DIV_Y, ST_DIV_Z:
					dcnt_q <= (dcnt_q == 7'(DSTEPS)) ? 7'd0 : dcnt_q + 7'd1;
				ST_OUT: ovalid_q <= 1'b1;
				default: ;
			endcase
			if (state_q == ST_PROJ && state_d == ST_DIV_X) dcnt_q <= '0;
		end
	end

	// datapath, no reset
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				src_q[0] <= s_axis_tdata[69:38];
				src_q[1] <= s_axis_tdata[101:70];
				src_q[2] <= s_axis_tdata[133:102];
				src_q[3] <= 32'sd1 <<< FRAC_BITS;
				acc_q <= '0;
			end
			ST_MODEL, ST_PROJ: begin
				if (rd_pend_q) begin
					if (step_q[1:0] == 2'd0) begin
						dst_q[step_q[3:2] - 2'd1] <= sat32(acc_nx);
						acc_q <= '0;
					end else begin
						acc_q <= acc_nx;
					end
				end
				if (state_q == ST_MODEL && step_q == 5'd16 && rd_pend_q) begin
					src_q[0] <= dst_q[0];
					src_q[1] <= dst_q[1];
					src_q[2] <= dst_q[2];
					src_q[3] <= sat32(acc_nx);
				end
				if (state_q == ST_PROJ && step_q == 5'd16 && rd_pend_q) begin
					src_q[3] <= sat32(acc_nx);
					ox_q <= '0;
					oy_q <= '0;
					oz_q <= '0;
					ptrue_q <= 1'b0;
				end
			end
			ST_DIV_X, ST_DIV_Y, ST_DIV_Z: begin
				if (dcnt_q == 7'(DSTEPS)) begin
					n_q[state_q == ST_DIV_X ? 0 : (state_q == ST_DIV_Y ? 1 : 2)]
						<= sat32(66'(qs));
				end
				if (dcnt_q == 7'd0) begin
					quo_q <= DW'(divsrc[31] ? -(64'(divsrc)) : 64'(divsrc)) << FRAC_BITS;
					rem_q <= '0;
					den_q <= DW'(src_q[3][31] ? -(64'(src_q[3])) : 64'(src_q[3]));
					neg_q <= divsrc[31] ^ src_q[3][31];
				end else begin
					rem_q <= rem_ge ? rem_sub : rem_sh;
					quo_q <= {quo_q[DW-2:0], rem_ge};
				end
			end
			ST_MAP_X: begin ox_q <= sat32(mapq); ptrue_q <= 1'b1; end
			ST_MAP_Y: oy_q <= sat32(mapq);
			ST_MAP_Z: oz_q <= sat32(mapq);
			default: ;
		endcase
	end

endmodule
